@@ hw/rtl/wafilt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wafilt_pkg
// Shared widths, types and constants of the 3x3 weighted mean filter.
// ----------------------------------------------------------------------------
package wafilt_pkg;

    localparam int PIX_W       = 8;
    localparam int DIM_W       = 11;
    localparam int WGT_W       = 4;
    localparam int TAPS        = 9;
    localparam int KW_W        = WGT_W * TAPS;
    localparam int POS_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = KW_W;

    localparam int ACC_W  = PIX_W + WGT_W + $clog2(TAPS);
    localparam int SUM_W  = WGT_W + $clog2(TAPS);
    localparam int NUM_W  = ACC_W + 1;
    localparam int DVS_W  = SUM_W + 1;
    localparam int REM_W  = DVS_W;
    localparam int STEP_W = $clog2(NUM_W);
    localparam int PROD_W = PIX_W + WGT_W;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int QUEUE_DEPTH    = 2;
    localparam int MIN_DIM        = 3;
    localparam int FIRST_FULL     = 2;

    localparam logic [DIM_W-1:0] IMAGE_DIM_RESET = 11'd1024;
    localparam logic [KW_W-1:0]  KERNEL_RESET    = 36'h111111111;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_KERNEL_WEIGHTS
    } cfg_index_t;

    typedef logic [TAPS-1:0][PIX_W-1:0] window_t;

    typedef struct packed {
        window_t            win;
        logic [POS_W-1:0]   out_row;
        logic [POS_W-1:0]   out_col;
    } work_t;

endpackage
`default_nettype wire

@@ hw/rtl/wafilt_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wafilt_if
// Valid/ready channels for incoming pixels and filtered results.
// ----------------------------------------------------------------------------
interface wafilt_pix_if import wafilt_pkg::*;;
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface wafilt_res_if import wafilt_pkg::*;;
    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   out_row;
    logic [POS_W-1:0]   out_col;
    logic [PIX_W-1:0]   filtered;
    logic               divide_fault;

    modport source (output valid, output out_row, output out_col, output filtered,
                    output divide_fault, input ready);
    modport sink   (input valid, input out_row, input out_col, input filtered,
                    input divide_fault, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/wafilt_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wafilt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wafilt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ hw/rtl/wafilt_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wafilt_front
// Pixel intake: raster counters, line stores and the 3x3 window.
// ----------------------------------------------------------------------------
module wafilt_front import wafilt_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    wafilt_pix_if.sink              pixels,
    input  wire logic [DIM_W-1:0]   image_width,
    input  wire logic [DIM_W-1:0]   image_height,
    input  wire logic               q_full,
    output logic                    q_push,
    output work_t                   q_item
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int MAXAR = (AW > RW) ? AW : RW;
    localparam int CMPW  = ((MAXAR > DIM_W) ? MAXAR : DIM_W) + 1;

    localparam logic [CMPW-1:0] MIN_C  = CMPW'(MIN_DIM);
    localparam logic [CMPW-1:0] MAXW_C = CMPW'(MAX_WIDTH);
    localparam logic [CMPW-1:0] MAXH_C = CMPW'(MAX_HEIGHT);

    typedef enum logic {ST_IDLE, ST_READ} state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      col_count_reg, col_count_next;
    logic [RW-1:0]      row_count_reg, row_count_next;
    logic [PIX_W-1:0]   px_reg, px_next;
    logic [AW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    window_t            win_reg, win_next;

    logic [CMPW-1:0]    w_in, h_in, w_lim, h_lim, c_inc, r_inc;
    logic [AW-1:0]      c_cur;
    logic [RW-1:0]      r_cur;
    logic [AW-1:0]      col_m1;
    logic [RW-1:0]      row_m1;
    logic [PIX_W-1:0]   above, above2;
    logic               accept, emit, ram_we;

    wafilt_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (px_reg),
        .raddr (c_cur),
        .rdata (above)
    );

    wafilt_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (above),
        .raddr (c_cur),
        .rdata (above2)
    );

    always_comb
    begin
        w_in  = CMPW'(image_width);
        h_in  = CMPW'(image_height);
        w_lim = (w_in < MIN_C) ? MIN_C : ((w_in > MAXW_C) ? MAXW_C : w_in);
        h_lim = (h_in < MIN_C) ? MIN_C : ((h_in > MAXH_C) ? MAXH_C : h_in);
        c_cur = (CMPW'(col_count_reg) >= w_lim) ? '0 : col_count_reg;
        r_cur = (CMPW'(row_count_reg) >= h_lim) ? '0 : row_count_reg;
        c_inc = CMPW'(c_cur) + CMPW'(1);
        r_inc = CMPW'(r_cur) + CMPW'(1);

        pixels.ready  = (state_reg == ST_IDLE) && !q_full;
        accept        = pixels.valid && (state_reg == ST_IDLE) && !q_full;
        ram_we        = (state_reg == ST_READ);
        emit          = (row_reg >= RW'(FIRST_FULL)) && (col_reg >= AW'(FIRST_FULL));
        col_m1        = col_reg - AW'(1);
        row_m1        = row_reg - RW'(1);

        state_next     = state_reg;
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        px_next        = px_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        win_next       = win_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    px_next  = pixels.pixel;
                    col_next = c_cur;
                    row_next = r_cur;
                    if (c_inc >= w_lim)
                    begin
                        col_count_next = '0;
                        row_count_next = (r_inc >= h_lim) ? '0 : r_inc[RW-1:0];
                    end
                    else
                    begin
                        col_count_next = c_inc[AW-1:0];
                        row_count_next = r_cur;
                    end
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_next[3*k]   = win_reg[3*k+1];
                    win_next[3*k+1] = win_reg[3*k+2];
                end
                win_next[2] = px_reg;
                win_next[5] = above;
                win_next[8] = above2;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        q_push         = ram_we && emit;
        q_item.win     = win_next;
        q_item.out_row = POS_W'(row_m1);
        q_item.out_col = POS_W'(col_m1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_count_reg <= '0;
            row_count_reg <= '0;
            win_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            win_reg       <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= px_next;
        col_reg <= col_next;
        row_reg <= row_next;
    end

endmodule
`default_nettype wire

@@ hw/rtl/wafilt_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wafilt_queue
// Small FIFO of filled windows between intake and arithmetic.
// ----------------------------------------------------------------------------
module wafilt_queue import wafilt_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  work_t       push_item,
    output logic        full,
    input  wire logic   pop,
    output work_t       pop_item,
    output logic        empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    work_t           entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    always_comb
    begin
        full     = (count_reg == CW'(DEPTH));
        empty    = (count_reg == '0);
        do_push  = push && !full;
        do_pop   = pop && !empty;
        pop_item = entry_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/wafilt_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wafilt_back
// Serial multiply-accumulate over the window, radix-2 divide, result register.
// ----------------------------------------------------------------------------
module wafilt_back import wafilt_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [KW_W-1:0]    kernel_weights,
    input  wire logic               q_empty,
    input  work_t                   q_item,
    output logic                    q_pop,
    wafilt_res_if.source            results
);

    typedef enum logic [2:0] {ST_IDLE, ST_MAC, ST_PREP, ST_DIV, ST_HOLD} state_t;

    state_t              state_reg, state_next;
    window_t             win_reg, win_next;
    logic [KW_W-1:0]     wgt_reg, wgt_next;
    logic [POS_W-1:0]    row_reg, row_next;
    logic [POS_W-1:0]    col_reg, col_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [NUM_W-1:0]    dvd_reg, dvd_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [PIX_W-1:0]    res_reg, res_next;
    logic                fault_reg, fault_next;
    logic                out_valid_reg, out_valid_next;
    logic [POS_W-1:0]    out_row_reg, out_row_next;
    logic [POS_W-1:0]    out_col_reg, out_col_next;
    logic [PIX_W-1:0]    out_pix_reg, out_pix_next;
    logic                out_fault_reg, out_fault_next;

    logic [PROD_W-1:0]   prod;
    logic [REM_W:0]      trial;
    logic                ge;

    always_comb
    begin
        prod  = PROD_W'(wgt_reg[WGT_W-1:0]) * PROD_W'(win_reg[0]);
        trial = {rem_reg, dvd_reg[NUM_W-1]};
        ge    = (trial >= {1'b0, dvs_reg});
        q_pop = (state_reg == ST_IDLE) && !q_empty;

        state_next     = state_reg;
        win_next       = win_reg;
        wgt_next       = wgt_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        sum_next       = sum_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_pix_next   = out_pix_reg;
        out_fault_next = out_fault_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    win_next   = q_item.win;
                    wgt_next   = kernel_weights;
                    row_next   = q_item.out_row;
                    col_next   = q_item.out_col;
                    acc_next   = '0;
                    sum_next   = '0;
                    step_next  = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                acc_next  = acc_reg + ACC_W'(prod);
                sum_next  = sum_reg + SUM_W'(wgt_reg[WGT_W-1:0]);
                win_next  = window_t'(win_reg >> PIX_W);
                wgt_next  = wgt_reg >> WGT_W;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(TAPS - 1))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                step_next = '0;
                rem_next  = '0;
                dvd_next  = {acc_reg, 1'b0} + NUM_W'(sum_reg);
                dvs_next  = {sum_reg, 1'b0};
                if (sum_reg == '0)
                begin
                    res_next   = '0;
                    fault_next = 1'b1;
                    state_next = ST_HOLD;
                end
                else
                begin
                    fault_next = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = ge ? REM_W'(trial - {1'b0, dvs_reg}) : REM_W'(trial);
                dvd_next  = {dvd_reg[NUM_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NUM_W - 1))
                begin
                    res_next   = (|dvd_next[NUM_W-1:PIX_W]) ? '1 : dvd_next[PIX_W-1:0];
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = row_reg;
                    out_col_next   = col_reg;
                    out_pix_next   = res_reg;
                    out_fault_next = fault_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        results.valid        = out_valid_reg;
        results.out_row      = out_row_reg;
        results.out_col      = out_col_reg;
        results.filtered     = out_pix_reg;
        results.divide_fault = out_fault_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg       <= win_next;
        wgt_reg       <= wgt_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        acc_reg       <= acc_next;
        sum_reg       <= sum_next;
        dvd_reg       <= dvd_next;
        dvs_reg       <= dvs_next;
        rem_reg       <= rem_next;
        res_reg       <= res_next;
        fault_reg     <= fault_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_pix_reg   <= out_pix_next;
        out_fault_reg <= out_fault_next;
    end

endmodule
`default_nettype wire

@@ hw/rtl/weighted_average_filter_3x3_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_average_filter_3x3_core
// Streaming 3x3 weighted mean filter for 8-bit raster pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the pixels channel; each one passes through
// the intake as a line store read, then a window and line store update; the
// intake takes no new pixel until that update is done, nor while the window
// queue is full. Each interior pixel then runs through the arithmetic unit:
// window taken from the queue, serial multiply-accumulate over the nine taps,
// setup, radix-2 division, result register load; the unit takes no new window
// until its result is loaded, which sets the sustained rate on interior pixels
// (a zero weight sum skips the division); a stalled result register adds its
// stall. A two-entry window queue lets the intake run ahead across border
// pixels. Results carry the centre row and column; border pixels give no
// result. A zero weight sum gives filtered = 0 with divide_fault set.
// Write image_width, image_height and kernel_weights only while the block is
// idle; out-of-range sizes are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.
// ----------------------------------------------------------------------------
module weighted_average_filter_3x3_core import wafilt_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    wafilt_pix_if.sink                  pixels,
    wafilt_res_if.source                results,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [DIM_W-1:0]   image_width_reg, image_width_next;
    logic [DIM_W-1:0]   image_height_reg, image_height_next;
    logic [KW_W-1:0]    kernel_weights_reg, kernel_weights_next;

    logic               q_push, q_full, q_pop, q_empty;
    work_t              push_item, pop_item;

    always_comb
    begin
        image_width_next    = image_width_reg;
        image_height_next   = image_height_reg;
        kernel_weights_next = kernel_weights_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:    image_width_next    = cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:   image_height_next   = cfg_data[DIM_W-1:0];
                CFG_KERNEL_WEIGHTS: kernel_weights_next = cfg_data[KW_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= IMAGE_DIM_RESET;
            image_height_reg   <= IMAGE_DIM_RESET;
            kernel_weights_reg <= KERNEL_RESET;
        end
        else
        begin
            image_width_reg    <= image_width_next;
            image_height_reg   <= image_height_next;
            kernel_weights_reg <= kernel_weights_next;
        end
    end

    wafilt_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixels       (pixels),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    wafilt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    wafilt_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .kernel_weights (kernel_weights_reg),
        .q_empty        (q_empty),
        .q_item         (pop_item),
        .q_pop          (q_pop),
        .results        (results)
    );

endmodule
`default_nettype wire

@@ hw/rtl/wafilt_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wafilt_checker
// Port-level checks of the weighted mean filter, bound to the top level.
// ----------------------------------------------------------------------------
module wafilt_checker import wafilt_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [POS_W-1:0]   out_row,
    input  wire logic [POS_W-1:0]   out_col,
    input  wire logic [PIX_W-1:0]   filtered,
    input  wire logic               divide_fault
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_col)
            && $stable(filtered) && $stable(divide_fault))
        else $error("result changed while stalled");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_fault |-> filtered == '0)
        else $error("faulted result is not zero");

    a_intake_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("intake took pixels on back-to-back cycles");

endmodule

bind weighted_average_filter_3x3_core wafilt_checker u_wafilt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (pixels.valid),
    .in_ready     (pixels.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_row      (results.out_row),
    .out_col      (results.out_col),
    .filtered     (results.filtered),
    .divide_fault (results.divide_fault)
);
`default_nettype wire

@@ sim/wafilt_result_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wafilt_result_checker
// Watches the pixel and result channels and the register port of the 3x3
// weighted mean filter. Every accepted pixel updates a private copy of the
// line stores, the window and the raster position, and each interior pixel
// queues the weighted mean it should produce. Every accepted result is
// compared field by field with the oldest queued mean.
// ----------------------------------------------------------------------------
module wafilt_result_checker import wafilt_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    wafilt_pix_if                       pixels,
    wafilt_res_if                       results,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          error_count,
    output int                          pending
);

    typedef struct packed {
        logic [POS_W-1:0]   out_row;
        logic [POS_W-1:0]   out_col;
        logic [PIX_W-1:0]   filtered;
        logic               divide_fault;
    } filter_result_t;

    filter_result_t     expected_means[$];
    logic [PIX_W-1:0]   line_above[MAX_WIDTH];
    logic [PIX_W-1:0]   line_above2[MAX_WIDTH];
    logic [PIX_W-1:0]   nbhd[TAPS];
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [KW_W-1:0]    weights_reg;
    int                 mismatches;

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] value, int unsigned hi);
        if (value < MIN_DIM)
            return MIN_DIM;
        if (value > hi)
            return hi;
        return value;
    endfunction

    task automatic filter_window_step(logic [PIX_W-1:0] px);
        int unsigned        w;
        int unsigned        h;
        int unsigned        c;
        int unsigned        r;
        int unsigned        acc;
        int unsigned        wsum;
        int unsigned        wt;
        int unsigned        mean;
        logic [PIX_W-1:0]   up1;
        logic [PIX_W-1:0]   up2;
        filter_result_t     want;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (col_pos >= w)
            col_pos = 0;
        if (row_pos >= h)
            row_pos = 0;
        c = col_pos;
        r = row_pos;
        up1 = line_above[c % MAX_WIDTH];
        up2 = line_above2[c % MAX_WIDTH];
        for (int k = 0; k < 3; k++)
        begin
            nbhd[3*k]   = nbhd[3*k+1];
            nbhd[3*k+1] = nbhd[3*k+2];
        end
        nbhd[2] = px;
        nbhd[5] = up1;
        nbhd[8] = up2;
        line_above2[c % MAX_WIDTH] = up1;
        line_above[c % MAX_WIDTH]  = px;
        if (r >= FIRST_FULL && c >= FIRST_FULL)
        begin
            acc  = 0;
            wsum = 0;
            for (int k = 0; k < TAPS; k++)
            begin
                wt   = weights_reg[WGT_W*k +: WGT_W];
                acc  += wt * nbhd[k];
                wsum += wt;
            end
            want.out_row = POS_W'(r - 1);
            want.out_col = POS_W'(c - 1);
            if (wsum == 0)
            begin
                want.filtered     = '0;
                want.divide_fault = 1'b1;
            end
            else
            begin
                mean = (2 * acc + wsum) / (2 * wsum);
                if (mean > 255)
                    mean = 255;
                want.filtered     = PIX_W'(mean);
                want.divide_fault = 1'b0;
            end
            expected_means.push_back(want);
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        filter_result_t want;
        if (expected_means.size() == 0)
        begin
            $error("result with nothing expected: row %0d col %0d",
                   results.out_row, results.out_col);
            mismatches++;
        end
        else
        begin
            want = expected_means.pop_front();
            compare_field("out_row", want.out_row, results.out_row);
            compare_field("out_col", want.out_col, results.out_col);
            compare_field("filtered", want.filtered, results.filtered);
            compare_field("divide_fault", want.divide_fault, results.divide_fault);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   = IMAGE_DIM_RESET;
            height_reg  = IMAGE_DIM_RESET;
            weights_reg = KERNEL_RESET;
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                line_above[i]  = '0;
                line_above2[i] = '0;
            end
            for (int i = 0; i < TAPS; i++)
                nbhd[i] = '0;
            col_pos = 0;
            row_pos = 0;
            expected_means.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:    width_reg   = cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT:   height_reg  = cfg_data[DIM_W-1:0];
                    CFG_KERNEL_WEIGHTS: weights_reg = cfg_data[KW_W-1:0];
                    default:            ;
                endcase
            end
            if (pixels.valid && pixels.ready)
                filter_window_step(pixels.pixel);
            if (results.valid && results.ready)
                check_result();
        end
        error_count <= mismatches;
        pending     <= expected_means.size();
    end

endmodule
`default_nettype wire

@@ sim/tb_weighted_average_filter_3x3_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_weighted_average_filter_3x3_core
// Streams pixel images through the 3x3 weighted mean filter under a range of
// image sizes and kernels: a short directed opening, a size change in the
// middle of an image, the widest and tallest sizes cut short by a resize, then
// many small random images. Both channels idle in random bursts; the checker
// beside the block predicts every result and counts mismatches for the final
// verdict.
// ----------------------------------------------------------------------------
module tb_weighted_average_filter_3x3_core;
    import wafilt_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 64;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int CALM_ITEMS    = 200;
    localparam int WIDE_PIXELS   = 40;
    localparam int TALL_ROWS     = 24;

    localparam int STYLE_RANDOM  = 0;
    localparam int STYLE_EXTREME = 1;
    localparam int STYLE_FLAT    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam logic [KW_W-1:0]      WEIGHTS_FULL    = '1;
    localparam logic [KW_W-1:0]      WEIGHTS_NONE    = '0;
    localparam logic [KW_W-1:0]      WEIGHTS_CENTRE  = 36'h000010000;
    localparam logic [PIX_W-1:0]     PIX_MAX         = '1;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     error_count;
    int                     pending;
    int                     cycle_count = 0;
    int                     gap_pct;
    int                     stall_pct;
    int                     stall_left;
    int                     geom_w;
    int                     geom_h;
    int                     pos_col;
    int                     pos_row;
    int                     sent_random;
    int                     style;
    logic [PIX_W-1:0]       flat_base;

    wafilt_pix_if pix_ch();
    wafilt_res_if res_ch();

    weighted_average_filter_3x3_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_ch),
        .results   (res_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wafilt_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixels      (pix_ch),
        .results     (res_ch),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .error_count (error_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // stall the result channel in random bursts
    initial
    begin
        res_ch.ready <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if ($urandom_range(99) < stall_pct)
            begin
                stall_left = $urandom_range(3);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    function automatic int clamp_size(int value, int hi);
        if (value < MIN_DIM)
            return MIN_DIM;
        if (value > hi)
            return hi;
        return value;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] dim_word(int value);
        logic [CFG_DATA_W-1:0] word;
        word = $urandom_range(1) ? CFG_DATA_W'({$urandom, $urandom}) : '0;
        word[DIM_W-1:0] = DIM_W'(value);
        return word;
    endfunction

    function automatic logic [KW_W-1:0] pick_weights();
        logic [KW_W-1:0] kw;
        kw = '0;
        case ($urandom_range(5))
            0: kw = KW_W'({$urandom, $urandom});
            1: kw = WEIGHTS_FULL;
            2: kw = WEIGHTS_NONE;
            3: kw[WGT_W*$urandom_range(TAPS-1) +: WGT_W] = WGT_W'($urandom_range(1, 15));
            4: kw = KERNEL_RESET;
            default:
                for (int k = 0; k < TAPS; k++)
                    kw[WGT_W*k +: WGT_W] = WGT_W'($urandom_range(3));
        endcase
        return kw;
    endfunction

    function automatic logic [PIX_W-1:0] next_pixel(int kind);
        if (kind == STYLE_EXTREME)
            return $urandom_range(1) ? PIX_MAX : '0;
        if (kind == STYLE_FLAT)
            return flat_base ^ PIX_W'($urandom_range(1));
        return PIX_W'($urandom);
    endfunction

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == CFG_IMAGE_WIDTH)
            geom_w = clamp_size(value[DIM_W-1:0], DEF_MAX_WIDTH);
        else if (idx == CFG_IMAGE_HEIGHT)
            geom_h = clamp_size(value[DIM_W-1:0], DEF_MAX_HEIGHT);
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] px);
        int hold;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            hold = $urandom_range(1, 4);
            pix_ch.valid <= 1'b0;
            repeat (hold) @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= px;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
        // track the raster position to know where images end
        if (pos_col >= geom_w)
            pos_col = 0;
        if (pos_row >= geom_h)
            pos_row = 0;
        if (pos_col + 1 >= geom_w)
        begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= geom_h) ? 0 : pos_row + 1;
        end
        else
            pos_col++;
    endtask

    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic finish_image();
        while (pos_col != 0 || pos_row != 0)
            send_pixel(next_pixel(STYLE_RANDOM));
    endtask

    task automatic set_idling(int pct);
        gap_pct = pct;
        stall_pct <= pct;
    endtask

    initial
    begin
        int pause_at;
        int pixels_in_image;
        rst_n        <= 1'b0;
        pix_ch.valid <= 1'b0;
        pix_ch.pixel <= '0;
        cfg_write    <= 1'b0;
        cfg_index    <= CFG_IMAGE_WIDTH;
        cfg_data     <= '0;
        gap_pct      = 0;
        stall_pct    <= 0;
        geom_w       = DEF_MAX_WIDTH;
        geom_h       = DEF_MAX_HEIGHT;
        pos_col      = 0;
        pos_row      = 0;
        flat_base    = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest image, undersized registers clamp up, saturated result
        write_register(CFG_IMAGE_WIDTH, dim_word(2));
        write_register(CFG_IMAGE_HEIGHT, dim_word(0));
        write_register(CFG_KERNEL_WEIGHTS, WEIGHTS_FULL);
        repeat (9) send_pixel(PIX_MAX);
        wait_idle();
        // zero weight sum
        write_register(CFG_KERNEL_WEIGHTS, WEIGHTS_NONE);
        write_register(CFG_SPARE_INDEX, CFG_DATA_W'({$urandom, $urandom}));
        repeat (9) send_pixel(next_pixel(STYLE_EXTREME));
        wait_idle();
        write_register(CFG_KERNEL_WEIGHTS, WEIGHTS_CENTRE);
        for (int n = 0; n < 9; n++)
            send_pixel((n == 4) ? PIX_MAX : '0);
        wait_idle();

        // shrink the size in the middle of an image
        set_idling(30);
        write_register(CFG_IMAGE_WIDTH, dim_word(8));
        write_register(CFG_IMAGE_HEIGHT, dim_word(8));
        write_register(CFG_KERNEL_WEIGHTS, pick_weights());
        repeat (27) send_pixel(next_pixel(STYLE_RANDOM));
        wait_idle();
        write_register(CFG_IMAGE_WIDTH, dim_word(3));
        repeat (3) send_pixel(next_pixel(STYLE_RANDOM));
        wait_idle();
        write_register(CFG_IMAGE_HEIGHT, dim_word(3));
        finish_image();
        wait_idle();

        // widest and tallest sizes, oversized registers clamp down, cut short
        set_idling(10);
        write_register(CFG_IMAGE_WIDTH, dim_word(2047));
        write_register(CFG_IMAGE_HEIGHT, dim_word(3));
        write_register(CFG_KERNEL_WEIGHTS, pick_weights());
        repeat (WIDE_PIXELS) send_pixel(next_pixel(STYLE_RANDOM));
        wait_idle();
        write_register(CFG_IMAGE_WIDTH, dim_word(3));
        finish_image();
        wait_idle();
        write_register(CFG_IMAGE_HEIGHT, dim_word(1025));
        write_register(CFG_KERNEL_WEIGHTS, pick_weights());
        repeat (TALL_ROWS * geom_w) send_pixel(next_pixel(STYLE_RANDOM));
        wait_idle();
        write_register(CFG_IMAGE_HEIGHT, dim_word(3));
        finish_image();
        wait_idle();

        sent_random = 0;
        while (sent_random < RANDOM_ITEMS)
        begin
            if (sent_random >= RANDOM_ITEMS - CALM_ITEMS)
                set_idling(0);
            else
                case ($urandom_range(2))
                    0: set_idling(0);
                    1: set_idling(15);
                    default: set_idling(40);
                endcase
            write_register(CFG_IMAGE_WIDTH,
                           dim_word(($urandom_range(7) == 0) ? $urandom_range(2)
                                                              : $urandom_range(3, 16)));
            write_register(CFG_IMAGE_HEIGHT,
                           dim_word(($urandom_range(7) == 0) ? $urandom_range(2)
                                                              : $urandom_range(3, 10)));
            write_register(CFG_KERNEL_WEIGHTS, pick_weights());
            repeat ($urandom_range(1, 2))
            begin
                pixels_in_image = geom_w * geom_h;
                pause_at = ($urandom_range(3) == 0) ? $urandom_range(pixels_in_image - 1) : -1;
                style = ($urandom_range(3) == 0) ? $urandom_range(STYLE_FLAT) : STYLE_RANDOM;
                flat_base = PIX_W'($urandom);
                for (int n = 0; n < pixels_in_image; n++)
                begin
                    send_pixel(next_pixel(style));
                    sent_random++;
                    if (n == pause_at)
                        wait_idle();
                end
            end
            wait_idle();
        end

        wait_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
hw/rtl/wafilt_pkg.sv
hw/rtl/wafilt_if.sv
hw/rtl/wafilt_ram.sv
hw/rtl/wafilt_front.sv
hw/rtl/wafilt_queue.sv
hw/rtl/wafilt_back.sv
hw/rtl/weighted_average_filter_3x3_core.sv
hw/rtl/wafilt_checker.sv
sim/wafilt_result_checker.sv
sim/tb_weighted_average_filter_3x3_core.sv
